### hdl/mpch_pkg.sv
package mpch_pkg;

   // Store depth and coordinate width
   localparam int MAX_POINTS  = 32;
   localparam int COORD_WIDTH = 32;

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = 2 * COORD_WIDTH;

   // Hull side codes
   localparam logic SIDE_LOWER = 1'b0;
   localparam logic SIDE_UPPER = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic [COORD_WIDTH-1:0]        mag_type;
   typedef logic [CNT_W-1:0]              cnt_type;
   typedef logic [IDX_W-1:0]              idx_type;

   // Signed product kept as sign and magnitude
   typedef struct packed {
      logic              neg;
      logic [PROD_W-1:0] mag;
   } smag_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_START,
      S_FIRST,
      S_EMIT,
      S_B_RD,
      S_B_LD,
      S_J_TEST,
      S_J_DIFF,
      S_J_ABS,
      S_J_MUL1,
      S_J_MUL2,
      S_J_CMP
   } state_type;

   // a < b on sign-magnitude products
   function automatic logic sm_less(smag_type a, smag_type b);
      logic r;
      if (a.neg != b.neg) begin
         r = a.neg;
      end else if (a.neg) begin
         r = a.mag > b.mag;
      end else begin
         r = a.mag < b.mag;
      end
      return r;
   endfunction

endpackage

### hdl/monotone_point_convex_hull_unit.sv
// Loading: one point per cycle, ready again in the next cycle.
// Scan: after the last point the FSM passes S_START and S_FIRST and shows the first
// vertex from S_EMIT; each later vertex passes S_B_RD and S_B_LD, then S_J_TEST to
// S_J_CMP per candidate point, with the one shared 32x32 multiplier doing two
// products per candidate. Output stalls hold the scan in S_EMIT.
// Reset (synchronous, active high) clears the FSM, point count, output valid
// and hull_side; the point store is not cleared.
module monotone_point_convex_hull_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [31:0]              req_point_x,
   input  logic signed [31:0]              req_point_y,
   input  logic                            req_is_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [31:0]              rsp_hull_x,
   output logic signed [31:0]              rsp_hull_y,
   output logic                            rsp_hull_last,
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data
);
   import mpch_pkg::*;

   state_type state_ff, state_in;

   // Point store
   coord_type x_mem [MAX_POINTS];
   coord_type y_mem [MAX_POINTS];
   coord_type rd_x_ff, rd_y_ff;
   idx_type   rd_addr;

   logic      side_ff;
   cnt_type   count_ff;
   cnt_type   cur_ff, best_ff, j_ff;
   cnt_type   cur_plus1, best_plus1;
   coord_type cx_ff, cy_ff, bx_ff, by_ff;
   diff_type  dxj_ff, dyj_ff, dxb_ff, dyb_ff;
   mag_type   mdxj_ff, mdyj_ff, mdxb_ff, mdyb_ff;
   logic      ndxj_ff, ndyj_ff, ndxb_ff, ndyb_ff;
   smag_type  lhs_ff, rhs_ff, prod;
   mag_type   mul_a, mul_b;
   logic      mul_neg;
   logic      take;
   logic      in_acc, out_free, emit_go, emit_last;

   logic              rsp_valid_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic              rsp_last_ff;

   assign in_acc     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cur_plus1  = cur_ff + CNT_W'(1);
   assign best_plus1 = best_ff + CNT_W'(1);
   assign emit_last  = !(best_plus1 < count_ff);

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_LOWER;
      end else if (csr_wr_en) begin
         side_ff <= csr_wr_data;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD:   if (in_acc && req_is_last) state_in = S_START;
         S_START:  state_in = S_FIRST;
         S_FIRST:  state_in = S_EMIT;
         S_EMIT: begin
            if (out_free) state_in = emit_last ? S_LOAD : S_B_RD;
         end
         S_B_RD:   state_in = S_B_LD;
         S_B_LD:   state_in = S_J_TEST;
         S_J_TEST: state_in = (j_ff < count_ff) ? S_J_DIFF : S_EMIT;
         S_J_DIFF: state_in = S_J_ABS;
         S_J_ABS:  state_in = S_J_MUL1;
         S_J_MUL1: state_in = S_J_MUL2;
         S_J_MUL2: state_in = S_J_CMP;
         S_J_CMP:  state_in = S_J_TEST;
         default:  state_in = S_LOAD;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      emit_go   = 1'b0;
      rd_addr   = j_ff[IDX_W-1:0];
      mul_a     = mdyj_ff;
      mul_b     = mdxb_ff;
      mul_neg   = ndyj_ff ^ ndxb_ff;
      case (state_ff)
         S_LOAD:  req_ready = 1'b1;
         S_START: rd_addr = '0;
         S_EMIT:  emit_go = out_free;
         S_B_RD:  rd_addr = cur_plus1[IDX_W-1:0];
         S_J_MUL2: begin
            mul_a   = mdyb_ff;
            mul_b   = mdxj_ff;
            mul_neg = ndyb_ff ^ ndxj_ff;
         end
         default: ;
      endcase
   end

   // Shared multiplier
   always_comb begin
      prod.mag = mul_a * mul_b;
      prod.neg = (prod.mag != '0) && mul_neg;
   end

   assign take = (side_ff == SIDE_UPPER) ? sm_less(rhs_ff, lhs_ff)
                                         : sm_less(lhs_ff, rhs_ff);

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (in_acc && (count_ff != CNT_W'(MAX_POINTS))) begin
         x_mem[count_ff[IDX_W-1:0]] <= req_point_x[COORD_WIDTH-1:0];
         y_mem[count_ff[IDX_W-1:0]] <= req_point_y[COORD_WIDTH-1:0];
      end
      rd_x_ff <= x_mem[rd_addr];
      rd_y_ff <= y_mem[rd_addr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (in_acc && (count_ff != CNT_W'(MAX_POINTS))) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (emit_go && emit_last) begin
            count_ff <= '0;
         end
      end
   end

   // Scan datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_FIRST: begin
            bx_ff   <= rd_x_ff;
            by_ff   <= rd_y_ff;
            best_ff <= '0;
         end
         S_EMIT: begin
            if (out_free) begin
               cx_ff  <= bx_ff;
               cy_ff  <= by_ff;
               cur_ff <= best_ff;
            end
         end
         S_B_LD: begin
            bx_ff   <= rd_x_ff;
            by_ff   <= rd_y_ff;
            dxb_ff  <= DIFF_W'(rd_x_ff) - DIFF_W'(cx_ff);
            dyb_ff  <= DIFF_W'(rd_y_ff) - DIFF_W'(cy_ff);
            best_ff <= cur_plus1;
            j_ff    <= cur_plus1 + CNT_W'(1);
         end
         S_J_DIFF: begin
            dxj_ff <= DIFF_W'(rd_x_ff) - DIFF_W'(cx_ff);
            dyj_ff <= DIFF_W'(rd_y_ff) - DIFF_W'(cy_ff);
         end
         S_J_ABS: begin
            // magnitudes of all four differences, side by side
            ndxj_ff <= dxj_ff[DIFF_W-1];
            ndyj_ff <= dyj_ff[DIFF_W-1];
            ndxb_ff <= dxb_ff[DIFF_W-1];
            ndyb_ff <= dyb_ff[DIFF_W-1];
            mdxj_ff <= dxj_ff[DIFF_W-1] ? mag_type'(-dxj_ff) : mag_type'(dxj_ff);
            mdyj_ff <= dyj_ff[DIFF_W-1] ? mag_type'(-dyj_ff) : mag_type'(dyj_ff);
            mdxb_ff <= dxb_ff[DIFF_W-1] ? mag_type'(-dxb_ff) : mag_type'(dxb_ff);
            mdyb_ff <= dyb_ff[DIFF_W-1] ? mag_type'(-dyb_ff) : mag_type'(dyb_ff);
         end
         S_J_MUL1: lhs_ff <= prod;
         S_J_MUL2: rhs_ff <= prod;
         S_J_CMP: begin
            if (take) begin
               best_ff <= j_ff;
               bx_ff   <= rd_x_ff;
               by_ff   <= rd_y_ff;
               dxb_ff  <= dxj_ff;
               dyb_ff  <= dyj_ff;
            end
            j_ff <= j_ff + CNT_W'(1);
         end
         default: ;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_go) begin
         rsp_x_ff    <= 32'(bx_ff);
         rsp_y_ff    <= 32'(by_ff);
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hull_x    = rsp_x_ff;
   assign rsp_hull_y    = rsp_y_ff;
   assign rsp_hull_last = rsp_last_ff;

endmodule

### hdl/mpch_checker.sv
module mpch_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_is_last,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [31:0] rsp_hull_x,
   input logic signed [31:0] rsp_hull_y,
   input logic              rsp_hull_last
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hull_x)
         && $stable(rsp_hull_y) && $stable(rsp_hull_last))
      else $error("stalled result changed");

   // A last point starts the scan and closes the input
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_last |=> !req_ready)
      else $error("input open after last point");

   // Loading takes one point per cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_is_last |=> req_ready)
      else $error("input closed during load");

   // Mid-chain vertex pending means the scan is still running
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hull_last |-> !req_ready)
      else $error("input open during scan");

   // Out of reset: loading, nothing to deliver
   assert property (@(posedge clock)
      $past(reset) |-> req_ready && !rsp_valid)
      else $error("bad state after reset");

endmodule

bind monotone_point_convex_hull_unit mpch_checker u_mpch_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_is_last   (req_is_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_hull_x    (rsp_hull_x),
   .rsp_hull_y    (rsp_hull_y),
   .rsp_hull_last (rsp_hull_last)
);

### tb/sv/monotone_point_convex_hull_unit_test.sv
module monotone_point_convex_hull_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mpch_pkg::*;

   // Cycles without any accepted transaction before the run is abandoned
   localparam int STALL_LIMIT = 20000;
   localparam int ITEM_TARGET = 200;
   localparam int CALM_AFTER  = 170;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   coord_type       req_point_x;
   coord_type       req_point_y;
   logic            req_is_last;
   logic            rsp_valid;
   logic            rsp_ready;
   coord_type       rsp_hull_x;
   coord_type       rsp_hull_y;
   logic            rsp_hull_last;
   logic            csr_wr_en;
   logic            csr_wr_data;

   bit              calm_tail;
   int              stall_cycles;
   int              items_sent;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
   } vertex_type;

   // Predicts the hull chain of each point set and checks emitted vertices
   class hull_scoreboard;
      coord_type    pt_x[MAX_POINTS];
      coord_type    pt_y[MAX_POINTS];
      int unsigned  held;
      logic         side;
      vertex_type   chain_q[$];
      int           failures;

      function new();
         held     = 0;
         side     = SIDE_LOWER;
         failures = 0;
      endfunction

      function int pending();
         return chain_q.size();
      endfunction

      // Store an accepted point; on the last one, wrap the chain
      function void note_point(coord_type x, coord_type y, logic last);
         int unsigned         cur;
         int unsigned         best;
         logic signed [65:0]  dy_j, dx_j, dy_b, dx_b, lhs, rhs;
         bit                  take;
         if (held < MAX_POINTS) begin
            pt_x[held] = x;
            pt_y[held] = y;
            held++;
         end
         if (!last) return;
         cur = 0;
         chain_q.push_back('{pt_x[0], pt_y[0], 1'b0});
         while (cur + 1 < held) begin
            best = cur + 1;
            for (int unsigned j = cur + 2; j < held; j++) begin
               dy_j = 66'(pt_y[j]) - 66'(pt_y[cur]);
               dx_j = 66'(pt_x[j]) - 66'(pt_x[cur]);
               dy_b = 66'(pt_y[best]) - 66'(pt_y[cur]);
               dx_b = 66'(pt_x[best]) - 66'(pt_x[cur]);
               // exact cross products, no division
               lhs  = dy_j * dx_b;
               rhs  = dy_b * dx_j;
               take = (side == SIDE_UPPER) ? (rhs < lhs) : (lhs < rhs);
               if (take) best = j;
            end
            cur = best;
            chain_q.push_back('{pt_x[cur], pt_y[cur], 1'b0});
         end
         chain_q[chain_q.size()-1].last = 1'b1;
         held = 0;
      endfunction

      function void check_vertex(coord_type x, coord_type y, logic last);
         vertex_type want;
         if (chain_q.size() == 0) begin
            $error("unexpected hull vertex x=%0d y=%0d last=%0b", x, y, last);
            failures++;
            return;
         end
         want = chain_q.pop_front();
         if (x !== want.x) begin
            $error("hull_x expected %0d, actual %0d", want.x, x);
            failures++;
         end
         if (y !== want.y) begin
            $error("hull_y expected %0d, actual %0d", want.y, y);
            failures++;
         end
         if (last !== want.last) begin
            $error("hull_last expected %0b, actual %0b", want.last, last);
            failures++;
         end
      endfunction
   endclass

   hull_scoreboard sb;

   monotone_point_convex_hull_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hull_x    (rsp_hull_x),
      .rsp_hull_y    (rsp_hull_y),
      .rsp_hull_last (rsp_hull_last),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result receiver: random stall bursts, none in the tail
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm_tail && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Result monitor and watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_vertex(rsp_hull_x, rsp_hull_y, rsp_hull_last);
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL monotone_point_convex_hull_unit");
         $finish;
      end
   end

   // One point transaction; valid holds until accepted
   task automatic send_point(coord_type x, coord_type y, logic last);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_is_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_point(x, y, last);
   endtask

   // Random sender idle burst
   task automatic sender_gap();
      if (!calm_tail && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13) - 1) @(negedge clock);
      end
   endtask

   // Hold off the sender until every vertex is out, then let the block settle
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_side(logic value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.side = value;
   endtask

   // A point set of n items; ordered sets have strictly increasing x
   task automatic send_random_set(int n, bit ordered);
      longint    span;
      longint    step_max;
      longint    xv;
      coord_type x;
      coord_type y;
      coord_type prev_x;
      int        y_mode;
      span = 64'd4294967295;
      case ($urandom_range(0, 2))
         0: begin
            step_max = 16;
         end
         1: begin
            step_max = 65536;
         end
         default: begin
            step_max = span / n;
         end
      endcase
      xv = longint'($urandom_range(0, 32'(span - longint'(n - 1) * step_max)))
           - 64'sd2147483648;
      y_mode = $urandom_range(0, 3);
      prev_x = '0;
      for (int i = 0; i < n; i++) begin
         if (ordered) begin
            if (i > 0) xv += longint'($urandom_range(1, 32'(step_max)));
            x = coord_type'(xv);
         end else if (i > 0 && $urandom_range(0, 3) == 0) begin
            x = prev_x;
         end else begin
            x = $urandom;
         end
         case (y_mode)
            0: begin
               y = $urandom;
            end
            1: begin
               y = int'($urandom_range(0, 200)) - 100;
            end
            2: begin
               // all points collinear: every comparison is a tie
               y = x;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: y = 32'h8000_0000;
                  1: y = 32'h7FFF_FFFF;
                  2: y = '0;
                  default: y = '1;
               endcase
            end
         endcase
         sender_gap();
         send_point(x, y, i == n - 1);
         prev_x = x;
      end
      items_sent += (n > MAX_POINTS) ? MAX_POINTS : n;
   endtask

   // Main sequence
   initial begin
      int set_num;
      int n;
      int pick;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_point_x  = '0;
      req_point_y  = '0;
      req_is_last  = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 1'b0;
      calm_tail    = 1'b0;
      stall_cycles = 0;
      items_sent   = 0;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_side(SIDE_LOWER);

      // single-point sets at the coordinate extremes
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      // widest x and y differences
      send_point(32'h8000_0000, 32'h0000_0000, 1'b0);
      send_point(32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      // collinear: ties keep the earliest point
      send_point(32'd0, 32'd0, 1'b0);
      send_point(32'd1, 32'd1, 1'b0);
      send_point(32'd2, 32'd2, 1'b0);
      send_point(32'd3, 32'd3, 1'b1);
      wait_drained();

      write_side(SIDE_UPPER);
      send_point(32'd0, 32'd0, 1'b0);
      send_point(32'd10, 32'd5, 1'b0);
      send_point(32'd20, 32'd10, 1'b0);
      send_point(32'd30, 32'd15, 1'b1);
      // x not increasing: equal and decreasing steps
      send_point(32'd5, 32'd0, 1'b0);
      send_point(32'd5, 32'd3, 1'b0);
      send_point(32'd2, 32'd1, 1'b0);
      send_point(-32'sd1, -32'sd7, 1'b1);
      // repeated point
      send_point(32'h0001_0000, 32'h0001_0000, 1'b0);
      send_point(32'h0001_0000, 32'h0001_0000, 1'b1);
      send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_point(-32'sd1, 32'h7FFF_FFFF, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      items_sent = 22;

      // random point sets
      set_num = 0;
      while (items_sent < ITEM_TARGET) begin
         if (set_num % 5 == 4) begin
            wait_drained();
            write_side(1'($urandom_range(0, 1)));
         end
         if (set_num == 2) begin
            n = MAX_POINTS;
         end else if (set_num == 6) begin
            // overflow: the trailing points, last one included, are dropped
            n = MAX_POINTS + 2;
         end else begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
               n = $urandom_range(1, 6);
            end else if (pick < 18) begin
               n = $urandom_range(7, 16);
            end else if (pick == 18) begin
               n = MAX_POINTS;
            end else begin
               n = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4);
            end
         end
         if (items_sent >= CALM_AFTER) calm_tail = 1'b1;
         send_random_set(n, $urandom_range(0, 6) != 0);
         set_num++;
      end

      wait_drained();
      repeat (30) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("PASS monotone_point_convex_hull_unit");
      end else begin
         $display("FAIL monotone_point_convex_hull_unit");
      end
      $finish;
   end

endmodule

### monotone_point_convex_hull_unit.f
hdl/mpch_pkg.sv
hdl/monotone_point_convex_hull_unit.sv
hdl/mpch_checker.sv
tb/sv/monotone_point_convex_hull_unit_test.sv
